@@ hdl/bds_pkg.sv @@
// shared constants and types for the 2x2 box downsampler
package bds_pkg;

	localparam int CHANS     = 4;
	localparam int CHAN_W    = 8;
	localparam int SUM_W     = CHAN_W + 1;
	localparam int QUAD_W    = CHAN_W + 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int SWIDTH_W  = 13;
	localparam int SHEIGHT_W = 16;
	localparam int NCH_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH   = 2'd0,
		REG_SRC_HEIGHT  = 2'd1,
		REG_CHANNEL_CNT = 2'd2
	} cfg_reg_t;

	typedef logic [CHANS-1:0][CHAN_W-1:0] chan_vec_t;
	typedef logic [SHEIGHT_W-1:0] row_t;

endpackage

@@ hdl/bds_if.sv @@
// stream and configuration interfaces of the 2x2 box downsampler
interface bds_pix_if;
	logic                        valid;
	logic                        ready;
	logic [bds_pkg::CHAN_W-1:0] chan0;
	logic [bds_pkg::CHAN_W-1:0] chan1;
	logic [bds_pkg::CHAN_W-1:0] chan2;
	logic [bds_pkg::CHAN_W-1:0] chan3;
	modport source (output valid, chan0, chan1, chan2, chan3, input ready);
	modport sink (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface bds_avg_if;
	logic                        valid;
	logic                        ready;
	logic [bds_pkg::CHAN_W-1:0] avg0;
	logic [bds_pkg::CHAN_W-1:0] avg1;
	logic [bds_pkg::CHAN_W-1:0] avg2;
	logic [bds_pkg::CHAN_W-1:0] avg3;
	logic                        end_of_image;
	modport source (output valid, avg0, avg1, avg2, avg3, end_of_image, input ready);
	modport sink (input valid, avg0, avg1, avg2, avg3, end_of_image, output ready);
endinterface

interface bds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bds_pkg::CFG_IDX_W-1:0] index;
	logic [bds_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/bds_ram.sv @@
// generic single-write, single-read ram with registered read data
module bds_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/box_downsample_2x2_top.sv @@
// top level of the 2x2 box downsampler: position tracking, line store, averaging
//
//  channel | role | transfer when     | payload
//  pix     | in   | valid && ready    | chan0..chan3
//  avg     | out  | valid && ready    | avg0..avg3, end_of_image
//  cfg     | in   | valid && ready    | index, data (ready always high)
//
// one pixel per cycle while the output is not stalled; a result is registered in
// the read stage (line store read), then in the output register
// the line store is written on odd columns of even rows and read on odd columns of odd rows
// reset clears position and valid flags and sets the sizes to their defaults; the line store itself is not cleared
// a stalled output holds one result in the output register and one in the read stage
module box_downsample_2x2_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int LANES     = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	bds_pix_if.sink        pix,
	bds_avg_if.source      avg,
	bds_cfg_if.sink        cfg
);

	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = LANES * bds_pkg::SUM_W;
	localparam int NCH_RST = (LANES < 4) ? LANES : 4;

	logic [WW-1:0]                  width_q;
	bds_pkg::row_t                  height_q;
	logic [bds_pkg::NCH_W-1:0]      nch_q;
	logic [CW-1:0]                  col_q;
	bds_pkg::row_t                  row_q;
	logic [LANES-1:0][bds_pkg::SUM_W-1:0] pair_sums_q;

	logic                                  valid_s1;
	logic                                  eoi_s1;
	logic [LANES-1:0][bds_pkg::SUM_W-1:0] pair_s1;

	logic                                  out_valid_q;
	bds_pkg::chan_vec_t                    avg_q;
	logic                                  eoi_q;

	bds_pkg::chan_vec_t                    chan_all;
	logic [LANES-1:0][bds_pkg::SUM_W-1:0] pair_now;
	logic [RW-1:0]                         store_rdata;
	logic [WW-1:0]                         col_ext;
	logic [WW-1:0]                         last_col;
	bds_pkg::row_t                         last_row;
	logic [AW-1:0]                         slot;
	logic                                  in_fire;
	logic                                  used;
	logic                                  odd_col;
	logic                                  odd_row;
	logic                                  store_we;
	logic                                  store_re;
	logic                                  eoi_now;
	logic                                  s1_fire;
	logic                                  col_wrap;
	logic                                  row_wrap;
	logic [bds_pkg::CHANS-1:0][bds_pkg::SUM_W-1:0] pair_all;
	logic [bds_pkg::CHANS-1:0][bds_pkg::SUM_W-1:0] above_all;
	bds_pkg::chan_vec_t                    avg_next;
	logic [31:0]                           cfg_val;
	logic [31:0]                           width_next;
	logic [31:0]                           height_next;
	logic [31:0]                           nch_next;

	assign chan_all = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		assign pair_now[k] = pair_sums_q[k] + {1'b0, chan_all[k]};
	end

	assign col_ext  = WW'(col_q);
	assign last_col = {width_q[WW-1:1], 1'b0};
	assign last_row = {height_q[bds_pkg::SHEIGHT_W-1:1], 1'b0};
	assign slot     = AW'(col_q >> 1);
	assign used     = (col_ext < last_col) && (row_q < last_row);
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];
	assign eoi_now  = (col_ext == last_col - WW'(1)) && (row_q == last_row - 16'd1);
	assign col_wrap = ({1'b0, col_ext} + (WW + 1)'(1)) >= {1'b0, width_q};
	assign row_wrap = ({1'b0, row_q} + 17'd1) >= {1'b0, height_q};

	assign s1_fire   = valid_s1 && (!out_valid_q || avg.ready);
	assign pix.ready = !valid_s1 || !out_valid_q || avg.ready;
	assign in_fire   = pix.valid && pix.ready;
	assign store_we  = in_fire && used && odd_col && !odd_row;
	assign store_re  = in_fire && used && odd_col && odd_row;

	bds_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(slot),
		.wdata(pair_now),
		.re   (store_re),
		.raddr(slot),
		.rdata(store_rdata)
	);

	// position and horizontal pair sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			pair_sums_q <= '0;
		end else if (in_fire) begin
			if (used && !odd_col) begin
				for (int k = 0; k < LANES; k++) begin
					pair_sums_q[k] <= {1'b0, chan_all[k]};
				end
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (store_re) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_re) begin
			pair_s1 <= pair_now;
			eoi_s1  <= eoi_now;
		end
	end

	always_comb begin
		pair_all  = '0;
		above_all = '0;
		for (int k = 0; k < LANES; k++) begin
			pair_all[k]  = pair_s1[k];
			above_all[k] = store_rdata[k*bds_pkg::SUM_W +: bds_pkg::SUM_W];
		end
		for (int i = 0; i < bds_pkg::CHANS; i++) begin
			avg_next[i] = '0;
			if (bds_pkg::NCH_W'(i) < nch_q) begin
				avg_next[i] = bds_pkg::CHAN_W'(
					(bds_pkg::QUAD_W'(above_all[i]) + bds_pkg::QUAD_W'(pair_all[i])) >> 2);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (avg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			avg_q <= avg_next;
			eoi_q <= eoi_s1;
		end
	end

	assign avg.valid        = out_valid_q;
	assign avg.avg0         = avg_q[0];
	assign avg.avg1         = avg_q[1];
	assign avg.avg2         = avg_q[2];
	assign avg.avg3         = avg_q[3];
	assign avg.end_of_image = eoi_q;

	// configuration, stored already clamped
	assign cfg.ready = 1'b1;
	assign cfg_val   = 32'(cfg.data);

	always_comb begin
		width_next = cfg_val & 32'h1FFF;
		if (width_next < 32'd2) begin
			width_next = 32'd2;
		end else if (width_next > 32'(MAX_WIDTH)) begin
			width_next = 32'(MAX_WIDTH);
		end
		height_next = cfg_val & 32'hFFFF;
		if (height_next < 32'd2) begin
			height_next = 32'd2;
		end
		nch_next = cfg_val & 32'h7;
		if (nch_next < 32'd1) begin
			nch_next = 32'd1;
		end else if (nch_next > 32'(NCH_RST)) begin
			nch_next = 32'(NCH_RST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(2);
			height_q <= 16'd2;
			nch_q    <= bds_pkg::NCH_W'(NCH_RST);
		end else if (cfg.valid && cfg.ready) begin
			case (bds_pkg::cfg_reg_t'(cfg.index))
				bds_pkg::REG_SRC_WIDTH: begin
					width_q <= WW'(width_next);
				end
				bds_pkg::REG_SRC_HEIGHT: begin
					height_q <= bds_pkg::SHEIGHT_W'(height_next);
				end
				bds_pkg::REG_CHANNEL_CNT: begin
					nch_q <= bds_pkg::NCH_W'(nch_next);
				end
				default: begin
				end
			endcase
		end
	end

endmodule
